// ===== src/chbs_pkg.sv =====
// package for the clipped histogram brightness score unit
// shared constants and types, no dependencies
package chbs_pkg;
  localparam int MaxPixelsLog2 = 22;
  localparam int Bins = 256;
  typedef enum logic [3:0] {
    ST_IDLE, ST_DROP, ST_CLIP_LO, ST_CLIP_HI, ST_SUM, ST_DIV, ST_SCORE, ST_OUT, ST_CLEAR
  } state_t;
  typedef struct packed {
    logic [7:0] pixel;
    logic       last_pixel;
  } item_t;
endpackage

// ===== src/clipped_histogram_brightness_score_unit.sv =====
// top level of the clipped histogram brightness score unit: item queue (front) feeding engine (back)
// a result follows each last pixel once the back has run its drop, clip, sum, divide and score steps
// throughput: one pixel per cycle while the back is idle; at each frame end the back is busy
// (walks, divide, output, clear sweep over all 256 bins) while the queue takes 4 pixels
// synchronous reset clears control and runs the clear sweep over all 256 bins before any pixel
module clipped_histogram_brightness_score_unit #(
  parameter int MaxPixelsLog2 = chbs_pkg::MaxPixelsLog2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // pixel
  input  logic        s_tlast,  // last_pixel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata   // score, mean_level_q8, low_level, high_level, zero fill
);
  chbs_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;
  logic [48:0] rd;
  assign in_item = '{pixel: s_tdata, last_pixel: s_tlast};
  chbs_fifo u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );
  chbs_back #(.MaxPixelsLog2(MaxPixelsLog2)) u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .res_valid(m_tvalid), .res_ready(m_tready), .res_data(rd)
  );
  assign m_tdata = {7'd0, rd};
endmodule

// ===== src/chbs_ram.sv =====
// generic single write, single read ram with registered read
// no dependencies
module chbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/chbs_fifo.sv =====
// short item queue that forms the front and feeds the back
// depends on chbs_pkg
module chbs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  chbs_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output chbs_pkg::item_t out_item
);
  chbs_pkg::item_t q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic push, pop;
  assign in_ready = (cnt != 3'd4);
  assign out_valid = (cnt != 3'd0);
  assign out_item = q[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  always_ff @(posedge clk) begin
    if (push) q[wp] <= in_item;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + {2'd0, push} - {2'd0, pop};
    end
  end
endmodule

// ===== src/chbs_back.sv =====
// histogram counting and end of frame evaluation
// depends on chbs_pkg and chbs_ram
module chbs_back #(
  parameter int MaxPixelsLog2 = chbs_pkg::MaxPixelsLog2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  chbs_pkg::item_t in_item,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [48:0]     res_data
);
  localparam int Cw = MaxPixelsLog2 + 1;
  localparam int Qw = Cw + 8;
  localparam int Nw = Qw + 9;
  localparam int Pw = Nw + 8;
  localparam int Dw = Cw + 33;
  localparam logic [32:0] DropMul = 33'd5497558139;
  localparam int DropShift = 31;

  chbs_pkg::state_t state, state_next;
  logic [Cw-1:0] total;
  logic [7:0] idx;
  logic [8:0] k;
  logic [Qw-1:0] amount, drop;
  logic [Qw-1:0] dlo, dhi;
  logic [7:0] lo_bin, hi_bin;
  logic [Nw-1:0] num;
  logic [Qw-1:0] den;
  logic [7:0] low, high;
  logic low_found;
  logic [Pw-1:0] rem, quo, dividend;
  logic [5:0] dstep;
  logic [16:0] mean;
  logic [15:0] score;
  logic [Dw-1:0] dprod;
  logic [Cw-1:0] cnt_r;

  logic we;
  logic [7:0] waddr, raddr;
  logic [Cw-1:0] wdata, rdata;
  chbs_ram #(.Width(Cw), .Depth(chbs_pkg::Bins)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // counting pipeline with forwarding
  logic p1_v, p2_v;
  logic [7:0] p1_a, p2_a;
  logic [Cw-1:0] p2_val, cur;
  logic cap_ok;
  assign cap_ok = (total < Cw'(1) << MaxPixelsLog2);
  assign in_ready = (state == chbs_pkg::ST_IDLE);
  logic take;
  assign take = in_valid && in_ready;
  assign cur = (p2_v && p2_a == p1_a) ? p2_val : rdata;

  // drop amount total * 256 / 100 by reciprocal multiplication
  assign dprod = Dw'(total) * Dw'(DropMul);

  logic [Qw-1:0] hq, hclip;
  assign hq = {cnt_r, 8'd0};
  always_comb begin
    hclip = hq;
    if (idx < lo_bin || idx > hi_bin) begin
      hclip = '0;
    end else begin
      if (idx == lo_bin) hclip = hq - ((hq >= dlo) ? dlo : hq);
      if (idx == hi_bin) hclip = hclip - ((hclip >= dhi) ? dhi : hclip);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      chbs_pkg::ST_IDLE: if (take && in_item.last_pixel) state_next = chbs_pkg::ST_DROP;
      chbs_pkg::ST_DROP: if (!p1_v && !p2_v) state_next = chbs_pkg::ST_CLIP_LO;
      chbs_pkg::ST_CLIP_LO: if (k == 9'd257) state_next = chbs_pkg::ST_CLIP_HI;
      chbs_pkg::ST_CLIP_HI: if (k == 9'd257) state_next = chbs_pkg::ST_SUM;
      chbs_pkg::ST_SUM: if (k == 9'd257) state_next = chbs_pkg::ST_DIV;
      chbs_pkg::ST_DIV: if (dstep == 6'(Pw)) state_next = chbs_pkg::ST_SCORE;
      chbs_pkg::ST_SCORE: state_next = chbs_pkg::ST_OUT;
      chbs_pkg::ST_OUT: if (res_ready && k != 9'd0) state_next = chbs_pkg::ST_CLEAR;
      chbs_pkg::ST_CLEAR: if (k == 9'd255) state_next = chbs_pkg::ST_IDLE;
      default: state_next = chbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = p1_a;
    wdata = cur + Cw'(1);
    raddr = in_item.pixel;
    if (state == chbs_pkg::ST_IDLE || state == chbs_pkg::ST_DROP) begin
      we = p1_v;
    end else if (state == chbs_pkg::ST_CLEAR) begin
      we = 1'b1;
      waddr = k[7:0];
      wdata = '0;
    end else if (state == chbs_pkg::ST_CLIP_HI) begin
      raddr = 8'(9'd255 - k);
    end else begin
      raddr = k[7:0];
    end
  end

  logic [Qw-1:0] h;
  assign h = {rdata, 8'd0};
  logic [Pw-1:0] trial;
  assign trial = {rem[Pw-2:0], dividend[Pw-1]};

  logic [17:0] mq9;
  logic [17:0] diff;
  logic [16:0] dh;
  assign mq9 = {1'b0, mean} + {1'b0, ({1'b0, low} + {1'b0, high}), 7'd0} + 18'd0;
  assign diff = (mq9 >= 18'd65536) ? mq9 - 18'd65536 : 18'd65536 - mq9;
  assign dh = 17'((diff + 18'd1) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chbs_pkg::ST_CLEAR;
      total <= '0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      k <= '0;
    end else begin
      state <= state_next;
      p1_v <= take && cap_ok;
      p2_v <= p1_v;
      if (take && cap_ok) total <= total + Cw'(1);
      if (state != state_next) k <= '0;
      else if (state != chbs_pkg::ST_OUT || k == 9'd0) k <= k + 9'd1;
      if (state == chbs_pkg::ST_CLEAR) total <= '0;
    end
    p1_a <= in_item.pixel;
    p2_a <= p1_a;
    p2_val <= cur + Cw'(1);
    idx <= 8'(k - 9'd1);
    cnt_r <= rdata;
    case (state)
      chbs_pkg::ST_DROP: begin
        drop <= Qw'(dprod >> DropShift);
        amount <= '0;
        lo_bin <= '0;
        hi_bin <= 8'd255;
        dlo <= '0;
        dhi <= '0;
      end
      chbs_pkg::ST_CLIP_LO, chbs_pkg::ST_CLIP_HI: begin
        if (k == 9'd0) amount <= drop;
        else if (k <= 9'd256 && amount != '0) begin
          if (state == chbs_pkg::ST_CLIP_LO) begin
            lo_bin <= 8'(k - 9'd1);
            dlo <= (h >= amount) ? amount : h;
          end else begin
            hi_bin <= 8'(9'd256 - k);
            dhi <= (((lo_bin == 8'(9'd256 - k)) ? h - dlo : h) >= amount) ? amount :
                   ((lo_bin == 8'(9'd256 - k)) ? h - dlo : h);
          end
          amount <= (h - ((state == chbs_pkg::ST_CLIP_HI && lo_bin == 8'(9'd256 - k)) ?
                    dlo : '0) >= amount) ? '0 :
                    amount - (h - ((state == chbs_pkg::ST_CLIP_HI &&
                    lo_bin == 8'(9'd256 - k)) ? dlo : '0));
        end
        num <= '0;
        den <= '0;
        low_found <= 1'b0;
        low <= 8'd255;
        high <= '0;
      end
      chbs_pkg::ST_SUM: begin
        if (k >= 9'd2) begin
          num <= num + Nw'(hclip) * Nw'({1'b0, idx} + 9'd1);
          den <= den + hclip;
          if (hclip != '0) begin
            high <= idx;
            if (!low_found) begin
              low <= idx;
              low_found <= 1'b1;
            end
          end
        end
        dividend <= '0;
        dstep <= '0;
      end
      chbs_pkg::ST_DIV: begin
        if (dstep == 6'd0) begin
          dividend <= {num, 8'd0};
          rem <= '0;
          quo <= '0;
        end else begin
          dividend <= {dividend[Pw-2:0], 1'b0};
          if (trial >= Pw'(den)) begin
            rem <= trial - Pw'(den);
            quo <= {quo[Pw-2:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[Pw-2:0], 1'b0};
          end
        end
        dstep <= dstep + 6'd1;
      end
      chbs_pkg::ST_SCORE: begin
        mean <= 17'(quo);
      end
      default: ;
    endcase
    score <= (dh >= 17'd32768) ? 16'd0 : 16'(17'd32768 - dh);
  end

  assign res_valid = (state == chbs_pkg::ST_OUT) && (k != 9'd0);
  assign res_data = {high, low, mean, score};
endmodule

// ===== sim/brightness_score_checker.sv =====
// checker for the clipped histogram brightness score unit
// watches both stream channels, predicts frame scores and compares them; uses chbs_pkg
module brightness_score_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  output int          fail_count,
  output int          pending_scores
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  high_level;
    logic [7:0]  low_level;
    logic [16:0] mean_level_q8;
    logic [15:0] score;
  } frame_score_t;

  logic [22:0] hist_count [chbs_pkg::Bins];
  logic [22:0] frame_pixels;
  frame_score_t score_queue [$];

  function automatic frame_score_t frame_brightness();
    logic [63:0] clipped [chbs_pkg::Bins];
    logic [63:0] drop_q8, left, num, den, mean_q8, m_q9, diff;
    frame_score_t r;
    int lo, hi, k, i;
    for (i = 0; i < chbs_pkg::Bins; i++) clipped[i] = 64'(hist_count[i]) << 8;
    drop_q8 = (64'(frame_pixels) * 256) / 100;
    for (k = 0; k < 2; k++) begin
      left = drop_q8;
      for (i = 0; i < chbs_pkg::Bins && left > 0; i++) begin
        int b;
        b = (k == 0) ? i : chbs_pkg::Bins - 1 - i;
        if (clipped[b] >= left) begin
          clipped[b] -= left;
          left = 0;
        end else begin
          left -= clipped[b];
          clipped[b] = 0;
        end
      end
    end
    num = 0;
    den = 0;
    for (i = 0; i < chbs_pkg::Bins; i++) begin
      num += clipped[i] * (i + 1);
      den += clipped[i];
    end
    mean_q8 = (den != 0) ? (num * 256) / den : 0;
    lo = 0;
    while (lo < chbs_pkg::Bins - 1 && clipped[lo] == 0) lo++;
    hi = chbs_pkg::Bins - 1;
    while (hi > 0 && clipped[hi] == 0) hi--;
    m_q9 = mean_q8 + 64'(lo + hi) * 128;
    diff = (m_q9 >= 65536) ? m_q9 - 65536 : 65536 - m_q9;
    diff = (diff + 1) >> 1;
    r.score = (diff >= 32768) ? 16'd0 : 16'(32768 - diff);
    r.mean_level_q8 = mean_q8[16:0];
    r.low_level = lo[7:0];
    r.high_level = hi[7:0];
    return r;
  endfunction

  assign pending_scores = score_queue.size();

  always @(posedge clk) begin
    frame_score_t want, got;
    if (rst) begin
      for (int i = 0; i < chbs_pkg::Bins; i++) hist_count[i] = '0;
      frame_pixels = '0;
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (frame_pixels < (23'd1 << chbs_pkg::MaxPixelsLog2)) begin
          hist_count[s_tdata] = hist_count[s_tdata] + 23'd1;
          frame_pixels = frame_pixels + 23'd1;
        end
        if (s_tlast) begin
          score_queue.insert(score_queue.size(), frame_brightness());
          for (int i = 0; i < chbs_pkg::Bins; i++) hist_count[i] = '0;
          frame_pixels = '0;
        end
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[48:0];
        if (score_queue.size() == 0) begin
          $error("unexpected score item %h", m_tdata);
          fail_count++;
        end else begin
          want = score_queue.pop_front();
          if (got.score !== want.score) begin
            $error("score expected %0d actual %0d", want.score, got.score);
            fail_count++;
          end
          if (got.mean_level_q8 !== want.mean_level_q8) begin
            $error("mean_level_q8 expected %0d actual %0d", want.mean_level_q8,
                   got.mean_level_q8);
            fail_count++;
          end
          if (got.low_level !== want.low_level) begin
            $error("low_level expected %0d actual %0d", want.low_level, got.low_level);
            fail_count++;
          end
          if (got.high_level !== want.high_level) begin
            $error("high_level expected %0d actual %0d", want.high_level, got.high_level);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== sim/testbench.sv =====
// top of the brightness score testbench: clock, reset, pixel stimulus and verdict
// depends on clipped_histogram_brightness_score_unit and brightness_score_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;
  int          fail_count;
  int          pending_scores;
  int          hold_cycles = 0;
  bit          hold_req = 0;
  int          burst_left = 0;

  always #6 clk = ~clk;

  clipped_histogram_brightness_score_unit dut (.*);

  brightness_score_checker checker_i (.*);

  always @(negedge clk) begin
    if (hold_req) begin
      hold_cycles = 3000;
      hold_req = 0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_pixel(input logic [7:0] pix, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1;
    s_tdata <= pix;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_scores();
    s_tvalid <= 0;
    @(negedge clk);
    while (pending_scores != 0) @(negedge clk);
  endtask

  task automatic send_frame(input int len, input int kind);
    logic [7:0] pix;
    int base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: pix = 8'($urandom_range(0, 255));
        1: pix = 8'(base + $urandom_range(0, 8));
        2: pix = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd255;
        default: pix = 8'(base);
      endcase
      send_pixel(pix, i == len - 1);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd128, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd127, 1'b0);
    send_pixel(8'd128, 1'b1);
    for (int i = 0; i < 8; i++) send_pixel(8'd1 << i, i == 7);
    for (int i = 0; i < 8; i++) send_pixel(~(8'd1 << i), i == 7);
    drain_scores();
    hold_req = 1;
    for (int f = 0; f < 4; f++) send_frame(3, 0);
    send_frame(250, 2);
    drain_scores();
    for (int f = 0; f < 45; f++)
      send_frame($urandom_range(1, 40), $urandom_range(0, 3));
    send_frame(200, 0);
    send_frame(150, 1);
    drain_scores();
    repeat (1200) @(negedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
